// File: design/cln_pkg.sv
// shared types, codes and constant tables for the character lcd nibble writer
package cln_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [15:0] SAT16 = 16'hFFFF;

  typedef enum logic [1:0] {
    OP_TEXT = 2'd0,
    OP_CMD  = 2'd1,
    OP_GOTO = 2'd2,
    OP_INIT = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    REG_PULSE      = 3'd0,
    REG_BYTE_GAP   = 3'd1,
    REG_SETUP      = 3'd2,
    REG_LINE1      = 3'd3,
    REG_LINE2      = 3'd4,
    REG_CLEAR_WAIT = 3'd5,
    REG_INIT_WAIT  = 3'd6
  } reg_index_t;

  localparam logic [7:0] CHAR_FF = 8'h0C;
  localparam logic [7:0] CHAR_LF = 8'h0A;
  localparam logic [7:0] CHAR_BS = 8'h08;

  localparam logic [7:0] CMD_CLEAR       = 8'h01;
  localparam logic [7:0] CMD_CURSOR_LEFT = 8'h10;
  localparam logic [7:0] CMD_SET_ADDR    = 8'h80;
  // set address plus 255, i.e. column counted from one, wrapped to 8 bits
  localparam logic [7:0] CMD_GOTO_BIAS   = 8'h7F;

  localparam logic [3:0] WAKE_NIB_A = 4'h3;
  localparam logic [3:0] WAKE_NIB_B = 4'h2;
  localparam int         WAKE_STEPS = 4;
  localparam logic [3:0] INIT_LAST_STEP = 4'd15;

  typedef struct packed {
    logic [7:0]  pulse_us;
    logic [7:0]  byte_gap_us;
    logic [7:0]  setup_us;
    logic [6:0]  line1_base;
    logic [6:0]  line2_base;
    logic [15:0] clear_wait_us;
    logic [15:0] init_clear_wait_us;
  } cfg_t;

  typedef struct packed {
    logic        init;
    logic [7:0]  data;
    logic        rs;
    logic [15:0] extra;
  } job_t;

  typedef struct packed {
    logic [3:0]  nibble;
    logic        rs;
    logic [7:0]  setup;
    logic [15:0] after;
    logic        last;
  } xfer_t;

  function automatic logic [7:0] init_cmd(input logic [2:0] k);
    logic [7:0] c;
    unique case (k)
      3'd0:    c = 8'h28;
      3'd1:    c = 8'h08;
      3'd2:    c = 8'h0C;
      3'd3:    c = 8'h06;
      3'd4:    c = 8'h02;
      3'd5:    c = 8'h01;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [15:0] wake_wait(input logic [1:0] k);
    return k[0] ? 16'd1000 : 16'd5000;
  endfunction

endpackage

// File: design/char_lcd_nibble_writer.sv
// top level of the character lcd nibble writer
// Turns requests into 4-bit LCD bus beats, one beat per cycle while the result
// side keeps popping: a text byte, raw command or cursor move gives two beats,
// an init request sixteen. A decoder classifies each request into a job, a
// four-entry job queue holds jobs, and the sequencer emits one nibble a cycle
// into an output register while it is popped; a request is taken each cycle
// the queue has room, so the sequencer, at two beats per byte request, sets
// the sustained rate. A request passes the job queue, then the output register.
module char_lcd_nibble_writer import cln_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  op,
  input  logic [7:0]  byte_value,
  input  logic [6:0]  column,
  input  logic [1:0]  row,
  output logic        empty,
  input  logic        pop,
  output logic [3:0]  nibble,
  output logic        reg_select,
  output logic [7:0]  setup_wait_us,
  output logic [15:0] after_wait_us,
  output logic        last,
  input  logic        write_en,
  input  logic [2:0]  reg_index,
  input  logic [15:0] write_data
);

  cfg_t  cfg;
  job_t  new_job;
  job_t  head_job;
  logic  head_valid;
  logic  job_done;
  logic  out_valid;
  xfer_t out_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pulse_us           <= 8'd3;
      cfg.byte_gap_us        <= 8'd6;
      cfg.setup_us           <= 8'd20;
      cfg.line1_base         <= 7'd0;
      cfg.line2_base         <= 7'd64;
      cfg.clear_wait_us      <= 16'd2000;
      cfg.init_clear_wait_us <= 16'd10000;
    end else if (write_en) begin
      case (reg_index_t'(reg_index))
        REG_PULSE:      cfg.pulse_us           <= write_data[7:0];
        REG_BYTE_GAP:   cfg.byte_gap_us        <= write_data[7:0];
        REG_SETUP:      cfg.setup_us           <= write_data[7:0];
        REG_LINE1:      cfg.line1_base         <= write_data[6:0];
        REG_LINE2:      cfg.line2_base         <= write_data[6:0];
        REG_CLEAR_WAIT: cfg.clear_wait_us      <= write_data;
        REG_INIT_WAIT:  cfg.init_clear_wait_us <= write_data;
        default: begin
        end
      endcase
    end
  end

  cln_front u_front (
    .op         (op),
    .byte_value (byte_value),
    .column     (column),
    .row        (row),
    .cfg        (cfg),
    .job        (new_job)
  );

  cln_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr     (push),
    .wr_job (new_job),
    .full   (full),
    .rd     (job_done),
    .rd_job (head_job),
    .valid  (head_valid)
  );

  cln_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .job       (head_job),
    .job_valid (head_valid),
    .job_done  (job_done),
    .pop       (pop),
    .out_valid (out_valid),
    .out_q     (out_q)
  );

  assign empty         = !out_valid;
  assign nibble        = out_q.nibble;
  assign reg_select    = out_q.rs;
  assign setup_wait_us = out_q.setup;
  assign after_wait_us = out_q.after;
  assign last          = out_q.last;

endmodule

// File: design/cln_front.sv
// request decoder: turns one request into a byte job or an init job
module cln_front import cln_pkg::*; (
  input  logic [1:0] op,
  input  logic [7:0] byte_value,
  input  logic [6:0] column,
  input  logic [1:0] row,
  input  cfg_t       cfg,
  output job_t       job
);

  logic [6:0] base;

  always_comb begin
    base = (row == 2'd1) ? cfg.line1_base : cfg.line2_base;
    job.init  = 1'b0;
    job.data  = byte_value;
    job.rs    = 1'b0;
    job.extra = '0;
    unique case (op_t'(op))
      OP_TEXT: begin
        if (byte_value == CHAR_FF) begin
          job.data  = CMD_CLEAR;
          job.extra = cfg.clear_wait_us;
        end else if (byte_value == CHAR_LF) begin
          job.data = CMD_SET_ADDR + {1'b0, cfg.line2_base};
        end else if (byte_value == CHAR_BS) begin
          job.data  = CMD_CURSOR_LEFT;
          job.extra = cfg.clear_wait_us;
        end else begin
          job.rs = 1'b1;
        end
      end
      OP_CMD: begin
        job.data = byte_value;
      end
      OP_GOTO: begin
        job.data = CMD_GOTO_BIAS + {1'b0, base} + {1'b0, column};
      end
      OP_INIT: begin
        job.init = 1'b1;
      end
      default: begin
        job.init = 1'b0;
      end
    endcase
  end

endmodule

// File: design/cln_queue.sv
// short job queue between the request decoder and the transfer sequencer
module cln_queue import cln_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr,
  input  job_t wr_job,
  output logic full,
  input  logic rd,
  output job_t rd_job,
  output logic valid
);

  job_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] head;
  logic [QPTR_W-1:0] tail;
  logic [QCNT_W-1:0] count;

  assign full   = (count == QCNT_W'(QUEUE_DEPTH));
  assign valid  = (count != '0);
  assign rd_job = mem[head];

  always_ff @(posedge clk) begin
    if (wr && !full) begin
      mem[tail] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (wr && !full) begin
        tail <= tail + 1'b1;
      end
      if (rd && valid) begin
        head <= head + 1'b1;
      end
      count <= count + QCNT_W'(wr && !full) - QCNT_W'(rd && valid);
    end
  end

endmodule

// File: design/cln_back.sv
// transfer sequencer: walks a job nibble by nibble into the output register
module cln_back import cln_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  job_t job,
  input  logic job_valid,
  output logic job_done,
  input  logic pop,
  output logic out_valid,
  output xfer_t out_q
);

  logic [3:0]  step;
  logic [3:0]  rel;
  logic [2:0]  k;
  logic        wake;
  logic        second;
  logic [7:0]  cur_byte;
  logic [15:0] extra;
  logic [16:0] sum;
  logic        load;
  xfer_t       cur;

  assign load     = job_valid && (!out_valid || pop);
  assign job_done = load && cur.last;

  always_comb begin
    rel      = step - 4'(WAKE_STEPS);
    k        = rel[3:1];
    wake     = job.init && (step[3:2] == 2'b00);
    second   = step[0];
    cur_byte = job.init ? init_cmd(k) : job.data;
    extra    = job.init ? ((k == 3'd5) ? cfg.init_clear_wait_us : '0) : job.extra;
    sum      = {9'b0, cfg.pulse_us};
    if (second) begin
      sum = {9'b0, cfg.pulse_us} + {9'b0, cfg.byte_gap_us} + {1'b0, extra};
    end
    if (wake) begin
      cur.nibble = (step[1:0] == 2'd3) ? WAKE_NIB_B : WAKE_NIB_A;
      cur.rs     = 1'b0;
      cur.setup  = '0;
      cur.after  = wake_wait(step[1:0]);
    end else begin
      cur.nibble = second ? cur_byte[3:0] : cur_byte[7:4];
      cur.rs     = job.rs && !job.init;
      cur.setup  = cfg.setup_us;
      cur.after  = sum[16] ? SAT16 : sum[15:0];
    end
    cur.last = job.init ? (step == INIT_LAST_STEP) : second;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        step <= cur.last ? '0 : step + 1'b1;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_q <= cur;
    end
  end

  a_byte_two_steps: assert property (@(posedge clk) disable iff (rst)
    (job_valid && !job.init) |-> (step[3:1] == 3'd0))
    else $error("byte job beyond its second nibble");

  a_last_rewinds: assert property (@(posedge clk) disable iff (rst)
    job_done |=> (step == '0))
    else $error("step counter not rewound after last beat");

  a_idle_at_start: assert property (@(posedge clk) disable iff (rst)
    !job_valid |-> (step == '0))
    else $error("step counter moved without a job");

endmodule
